### hw/rtl/crcms_pkg.sv
// Shared types and constants for the MSB-first CRC-32 stream engine.
package crcms_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CRC_W-1:0] CRC_RESET_POLY = 32'h1EDC_6F41;
  localparam logic [CRC_W-1:0] CRC_RESET_INIT = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 1'b1;

  typedef struct packed {
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] initial_value;
  } crcms_cfg_t;

endpackage

### hw/rtl/crcms_cfg.sv
// Configuration register file: polynomial and initial value.
module crcms_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [crcms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crcms_pkg::CRC_W-1:0]       cfg_data,
  output crcms_pkg::crcms_cfg_t             cfg
);
  import crcms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.polynomial    <= CRC_RESET_POLY;
      cfg.initial_value <= CRC_RESET_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLYNOMIAL:    cfg.polynomial    <= cfg_data;
        CFG_INITIAL_VALUE: cfg.initial_value <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/crcms_fold.sv
// Folds one message byte into the running remainder, eight bit steps.
module crcms_fold (
  input  logic [crcms_pkg::CRC_W-1:0]  rem_in,
  input  logic [crcms_pkg::BYTE_W-1:0] data_byte,
  input  logic [crcms_pkg::CRC_W-1:0]  polynomial,
  output logic [crcms_pkg::CRC_W-1:0]  rem_out
);
  import crcms_pkg::*;

  logic [CRC_W-1:0] acc;

  always_comb begin
    acc = {rem_in[CRC_W-1 -: BYTE_W] ^ data_byte, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (acc[CRC_W-1]) begin
        acc = {acc[CRC_W-2:0], 1'b0} ^ polynomial;
      end else begin
        acc = {acc[CRC_W-2:0], 1'b0};
      end
    end
    rem_out = {rem_in[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}} ^ acc;
  end

endmodule

### hw/rtl/crc32_msb_first_stream_top.sv
// Pipeline: a word in the input register passes the combinational eight-step
// fold into the remainder register; a last word also loads the result word.
// Throughput: one word per cycle; a last word stalls in the input register
// while the result register holds a word the master side has not taken.
// Reset (rst, synchronous): both stages empty, polynomial 0x1EDC6F41,
// initial value and remainder all ones.
module crc32_msb_first_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic [1:0]  s_axis_tuser,   // [0] byte_valid, [1] start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] crc_value
  input  logic        cfg_we,
  input  logic [crcms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crcms_pkg::CRC_W-1:0]     cfg_data
);
  import crcms_pkg::*;

  crcms_cfg_t       cfg;
  logic             in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic             in_byte_valid;
  logic             in_start;
  logic             in_last;
  logic [CRC_W-1:0] remainder;
  logic [CRC_W-1:0] base_rem;
  logic [CRC_W-1:0] folded_rem;
  logic [CRC_W-1:0] remainder_next;
  logic             out_free;
  logic             in_fire;

  crcms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign base_rem = in_start ? cfg.initial_value : remainder;

  crcms_fold u_fold (
    .rem_in     (base_rem),
    .data_byte  (in_byte),
    .polynomial (cfg.polynomial),
    .rem_out    (folded_rem)
  );

  assign remainder_next = in_byte_valid ? folded_rem : base_rem;
  assign out_free       = !m_axis_tvalid || m_axis_tready;
  assign in_fire        = in_valid && (!in_last || out_free);
  assign s_axis_tready  = !in_valid || in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      in_byte       <= s_axis_tdata;
      in_byte_valid <= s_axis_tuser[0];
      in_start      <= s_axis_tuser[1];
      in_last       <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder     <= CRC_RESET_INIT;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        remainder <= remainder_next;
      end
      if (in_fire && in_last) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (in_fire && in_last) begin
      m_axis_tdata <= ~remainder_next;
    end
  end

endmodule

### hw/rtl/crcms_checker.sv
// Port-level checks for the CRC-32 stream engine, bound to the top level.
module crcms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed or dropped");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled while result side can take a word");

endmodule

bind crc32_msb_first_stream_top crcms_checker u_crcms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/crc32_msb_first_stream_top_tb.sv
// Self-checking testbench for the MSB-first CRC-32 stream engine.
module crc32_msb_first_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crcms_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES   = 4;
  localparam int DIR_N          = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              start_req;
    logic              last;
  } crc_word_t;

  typedef struct packed {
    crc_word_t        word;
    logic             has_crc;
    logic [CRC_W-1:0] crc;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [7:0] data_byte
  logic              s_axis_tlast;
  logic [1:0]        s_axis_tuser;   // [0] byte_valid, [1] start_req
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // [31:0] crc_value
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CRC_W-1:0]  cfg_data;

  logic [CRC_W-1:0] crc_exp_q[$];
  logic [CRC_W-1:0] pred_rem;
  logic [CRC_W-1:0] pred_poly;
  logic [CRC_W-1:0] pred_init;
  int               n_errors;
  int               idle_cycles;
  bit               idle_en;
  bit               rx_hold_req;
  dir_row_t         dir_tab [DIR_N];

  crc32_msb_first_stream_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] rem,
                                                input logic [BYTE_W-1:0] data,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] acc;
    int k;
    acc = {rem[31:24] ^ data, 24'h0};
    for (k = 0; k < 8; k++) begin
      if (acc[31]) begin
        acc = (acc << 1) ^ poly;
      end else begin
        acc = acc << 1;
      end
    end
    return (rem << 8) ^ acc;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input crc_word_t w, input bit has_typed,
                           input logic [CRC_W-1:0] typed);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.data_byte;
    s_axis_tuser  <= {w.start_req, w.byte_valid};
    s_axis_tlast  <= w.last;
    do @(posedge clk); while (!s_axis_tready);
    if (w.start_req) begin
      pred_rem = pred_init;
    end
    if (w.byte_valid) begin
      pred_rem = crc_fold(pred_rem, w.data_byte, pred_poly);
    end
    if (w.last) begin
      crc_exp_q.push_back(has_typed ? typed : ~pred_rem);
    end
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if (idle_en && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (crc_exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_cfg(input bit wr_poly, input logic [CRC_W-1:0] poly,
                           input bit wr_init, input logic [CRC_W-1:0] init);
    wait_drained();
    if (wr_poly) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_POLYNOMIAL;
      cfg_data  <= poly;
      @(negedge clk);
      pred_poly = poly;
    end
    if (wr_init) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INITIAL_VALUE;
      cfg_data  <= init;
      @(negedge clk);
      pred_init = init;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_traffic(input int n_items);
    int sent;
    int len;
    int r;
    crc_word_t w;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          len = 0;
        end else if (r < 14) begin
          len = $urandom_range(13, 40);
        end else begin
          len = $urandom_range(1, 12);
        end
        if (len == 0) begin
          w.data_byte  = 8'($urandom);
          w.byte_valid = 1'b0;
          w.start_req  = 1'b1;
          w.last       = 1'b1;
          send_word(w, 1'b0, '0);
          idle_gap();
          sent++;
        end else begin
          for (int i = 0; i < len; i++) begin
            w.data_byte  = 8'($urandom);
            w.byte_valid = ($urandom_range(0, 15) != 0);
            w.start_req  = (i == 0);
            w.last       = (i == len - 1);
            send_word(w, 1'b0, '0);
            idle_gap();
            if (w.byte_valid || w.start_req || w.last) begin
              sent++;
            end
          end
        end
      end else begin
        w = crc_word_t'($urandom_range(0, 2047));
        send_word(w, 1'b0, '0);
        idle_gap();
        if (w.byte_valid || w.start_req || w.last) begin
          sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len() - 1) @(negedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (crc_exp_q.size() == 0) begin
          $display("%0t: unexpected crc_value %08h, nothing pending", $time, m_axis_tdata);
          n_errors++;
        end else begin
          if (m_axis_tdata !== crc_exp_q[0]) begin
            $display("%0t: crc_value mismatch: expected %08h, actual %08h",
                     $time, crc_exp_q[0], m_axis_tdata);
            n_errors++;
          end
          void'(crc_exp_q.pop_front());
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results pending",
                 $time, STALL_LIMIT, crc_exp_q.size());
        $display("crc32_msb_first_stream_top_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_POLYNOMIAL;
    cfg_data      = '0;
    n_errors      = 0;
    idle_cycles   = 0;
    idle_en       = 1'b1;
    rx_hold_req   = 1'b0;
    pred_rem      = CRC_RESET_INIT;
    pred_poly     = CRC_RESET_POLY;
    pred_init     = CRC_RESET_INIT;

    // data, byte_valid, start_req, last | typed result
    dir_tab = '{
      '{'{8'h00, 1'b0, 1'b0, 1'b1}, 1'b1, 32'h0000_0000},
      '{'{8'hFF, 1'b0, 1'b1, 1'b1}, 1'b1, 32'h0000_0000},
      '{'{8'h00, 1'b1, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'hFF, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'hA5, 1'b0, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h80, 1'b1, 1'b0, 1'b1}, 1'b0, 32'h0},
      '{'{8'h01, 1'b1, 1'b0, 1'b1}, 1'b0, 32'h0},
      '{'{8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, 32'h0},
      '{'{8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'h55, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'hAA, 1'b1, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'h3C, 1'b0, 1'b0, 1'b1}, 1'b0, 32'h0},
      '{'{8'h31, 1'b1, 1'b1, 1'b0}, 1'b0, 32'h0},
      '{'{8'h32, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h33, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h34, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h35, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h36, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h37, 1'b1, 1'b0, 1'b0}, 1'b0, 32'h0},
      '{'{8'h38, 1'b1, 1'b0, 1'b1}, 1'b0, 32'h0}
    };

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_word(dir_tab[i].word, dir_tab[i].has_crc, dir_tab[i].crc);
      idle_gap();
    end
    s_axis_tvalid <= 1'b0;

    run_traffic(10);
    rx_hold_req = 1'b1;
    run_traffic(50);

    apply_cfg(1'b1, 32'h0000_0000, 1'b1, 32'h0000_0000);
    run_traffic(50);

    apply_cfg(1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    idle_en = 1'b0;
    run_traffic(50);
    idle_en = 1'b1;

    apply_cfg(1'b1, 32'h04C1_1DB7, 1'b0, '0);
    run_traffic(25);
    wait_drained();
    run_traffic(25);

    apply_cfg(1'b0, '0, 1'b1, $urandom);
    run_traffic(50);

    apply_cfg(1'b1, $urandom, 1'b1, $urandom);
    run_traffic(60);

    apply_cfg(1'b1, CRC_RESET_POLY, 1'b1, CRC_RESET_INIT);
    run_traffic(60);

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0 && crc_exp_q.size() == 0) begin
      $display("crc32_msb_first_stream_top_tb: PASS");
    end else begin
      $display("crc32_msb_first_stream_top_tb: FAIL");
    end
    $finish;
  end

endmodule
